// ----- sv/qrs_pkg.sv -----
// qrs_pkg: word types, register indexes, phase codes and reset values for the qrs peak detector
package qrs_pkg;

    // input word: one filtered sample and its time stamp
    typedef struct packed {
        logic signed [31:0] sample;
        logic [31:0]        time_stamp;
    } t_in_word;

    // output word: peak flag and the time stamp of the confirmed peak
    typedef struct packed {
        logic        peak_found;
        logic [31:0] peak_time;
    } t_out_word;

    // configuration register indexes
    localparam int unsigned CfgAddrW = 2;
    typedef enum logic [CfgAddrW-1:0] {
        CFG_PEAK_THRESHOLD = 2'd0,
        CFG_FALL_MARGIN    = 2'd1,
        CFG_WINDOW_LEN     = 2'd2
    } t_cfg_addr;

    // detector phases, one-hot
    typedef enum logic [3:0] {
        PH_REARM  = 4'b0001,
        PH_SEARCH = 4'b0010,
        PH_PROV   = 4'b0100,
        PH_WAIT   = 4'b1000
    } t_phase;

    // reset values
    localparam logic signed [31:0] ThresholdRst = 32'sd0;
    localparam logic [30:0]        MarginRst    = 31'd0;
    localparam logic [7:0]         WindowRst    = 8'd72;
    localparam logic signed [31:0] MaxValueRst  = -32'sd1000;
    localparam logic signed [31:0] MaxValueArm  = -32'sd1;
    localparam logic [31:0]        MaxTimeRst   = 32'hFFFF_FFFF;
    localparam logic [7:0]         RefracRst    = 8'd72;

endpackage

// ----- sv/qrs_peak_detector.sv -----
// qrs_peak_detector: ecg qrs peak detector with refractory window, one sample per cycle unless the output stalls
//
// Usage
//   Input channel i_in_valid / o_in_ready carries one word: a signed sample and its
//   time stamp. Output channel o_out_valid / i_out_ready returns exactly one word per
//   input word: peak_found and peak_time (zero unless a peak is confirmed).
//   Configuration is a plain write port (i_cfg_wen, i_cfg_addr, i_cfg_wdata): index 0
//   peak threshold, 1 fall margin, 2 window length; other indexes are ignored. Write
//   it only while no word is in flight.
//   The result word is registered at the edge that accepts the input word. Throughput
//   is one word per cycle while the receiver takes each word, set by the result register
//   that is written at the same edge as the phase update.
//   When the receiver stalls, the result register holds its word and o_in_ready falls
//   until that word is taken; a word can be accepted in the same cycle the held one
//   leaves.
//   Reset (i_rst_n low, synchronous) restores the register defaults (threshold 0,
//   margin 0, window 72), puts the detector in the rearm phase and empties the output.
module qrs_peak_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [qrs_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [31:0]                   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  qrs_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output qrs_pkg::t_out_word            o_out_word
);
    import qrs_pkg::*;

    // configuration registers
    logic signed [31:0] r_threshold;
    logic [30:0]        r_margin;
    logic [7:0]         r_window;

    // detector state
    t_phase             r_phase, n_phase;
    logic signed [31:0] r_max_value, n_max_value;
    logic [31:0]        r_max_time, n_max_time;
    logic [7:0]         r_refrac, n_refrac;

    // output register
    logic               r_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               w_in_fire;
    logic               w_above;
    logic signed [32:0] w_smp_ext;
    logic signed [32:0] w_lim;
    logic               w_fell;
    logic               w_higher;
    logic [31:0]        w_diff;
    logic               w_in_window;
    logic signed [31:0] w_half;

    // handshake
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThresholdRst;
            r_margin    <= MarginRst;
            r_window    <= WindowRst;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                CFG_PEAK_THRESHOLD: r_threshold <= $signed(i_cfg_wdata);
                CFG_FALL_MARGIN:    r_margin    <= i_cfg_wdata[30:0];
                CFG_WINDOW_LEN:     r_window    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // compares used by the phases
    assign w_above     = r_max_value > r_threshold;
    assign w_smp_ext   = {i_in_word.sample[31], i_in_word.sample};
    assign w_lim       = {r_max_value[31], r_max_value} - $signed({2'b00, r_margin});
    assign w_fell      = w_smp_ext < w_lim;
    assign w_higher    = i_in_word.sample > r_max_value;
    assign w_diff      = i_in_word.time_stamp - r_max_time;
    assign w_in_window = w_diff < {24'd0, r_window};
    assign w_half      = {r_max_value[31], r_max_value[31:1]};

    // next state and result word
    always_comb begin
        n_phase     = r_phase;
        n_max_value = r_max_value;
        n_max_time  = r_max_time;
        n_refrac    = r_refrac;
        n_out_word  = '0;
        case (r_phase)
            PH_REARM: begin
                n_phase     = PH_SEARCH;
                n_max_value = MaxValueArm;
                n_max_time  = MaxTimeRst;
            end
            PH_SEARCH: begin
                if (w_above && w_fell) begin
                    n_phase = PH_PROV;
                end else if (w_higher) begin
                    n_max_value = i_in_word.sample;
                    n_max_time  = i_in_word.time_stamp;
                end
            end
            PH_PROV: begin
                if (w_higher && w_in_window) begin
                    n_max_value = i_in_word.sample;
                    n_max_time  = i_in_word.time_stamp;
                end else if (i_in_word.sample < w_half) begin
                    n_out_word.peak_found = 1'b1;
                    n_out_word.peak_time  = r_max_time;
                    n_phase               = PH_WAIT;
                    // countdown of the rest of the window, clamped at zero
                    n_refrac = w_in_window ? (r_window - w_diff[7:0]) : 8'd0;
                end
            end
            PH_WAIT: begin
                if (r_refrac == 8'd0) begin
                    n_phase = PH_REARM;
                end else begin
                    n_refrac = r_refrac - 8'd1;
                end
            end
            default: begin
                n_phase = PH_REARM;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_REARM;
            r_max_value <= MaxValueRst;
            r_max_time  <= MaxTimeRst;
            r_refrac    <= RefracRst;
        end else if (w_in_fire) begin
            r_phase     <= n_phase;
            r_max_value <= n_max_value;
            r_max_time  <= n_max_time;
            r_refrac    <= n_refrac;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_word <= n_out_word;
        end
    end

`ifndef NO_ASSERTIONS
    // a peak can only be reported from the provisional phase
    a_peak_from_prov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && r_phase != PH_PROV |=> !o_out_word.peak_found)
        else $error("peak reported outside provisional phase");

    // no peak, no time stamp
    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.peak_found |-> o_out_word.peak_time == 32'd0)
        else $error("peak_time not zero without a peak");

    // an expired countdown rearms the detector
    a_wait_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && r_phase == PH_WAIT && r_refrac == 8'd0 |=> r_phase == PH_REARM)
        else $error("wait phase did not rearm");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a held result");
`endif

endmodule
